/* hw/rtl/idr_pkg.sv */
// shared types, constants and the crc step function for the image download receiver
package idr_pkg;

    // chunk size in bytes and width of the chunk fill counter
    localparam int CHUNK_BYTES = 256;
    localparam int FILL_W      = $clog2(CHUNK_BYTES + 1);

    // crc-32, reflected form
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // command queue depth between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // config register
    localparam int MAXLEN_W           = 24;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 24'd56320;
    localparam logic REG_MAX_IMAGE_LENGTH = 1'b0;

    // received command bytes
    localparam logic [7:0] CMD_REQUEST = 8'd2;
    localparam logic [7:0] CMD_LENGTH  = 8'd3;
    localparam logic [7:0] CMD_CRC     = 8'd5;

    // reply codes
    localparam logic [2:0] RSP_ERR     = 3'd0;
    localparam logic [2:0] RSP_OK      = 3'd1;
    localparam logic [2:0] RSP_CHUNK   = 3'd4;
    localparam logic [2:0] RSP_CRC_OK  = 3'd6;
    localparam logic [2:0] RSP_CRC_ERR = 3'd7;

    // result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_STORE = 1'b1;

    // operations handed from front to back
    typedef enum logic [1:0] {
        OP_ERROR = 2'd0,
        OP_START = 2'd1,
        OP_STORE = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    // one queue entry
    typedef struct packed {
        op_t         op;
        logic [23:0] offset;
        logic [7:0]  data;
        logic        ack;
        logic [31:0] expected;
    } cmd_t;

    // protocol phase of the front end
    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_LEN_CMD   = 6'b000010,
        PH_LEN_BYTES = 6'b000100,
        PH_DATA      = 6'b001000,
        PH_CRC_CMD   = 6'b010000,
        PH_CRC_BYTES = 6'b100000
    } phase_t;

    // fold one byte into the crc register
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/image_download_receiver_crc32_core.sv */
// top level of the image download receiver: config register and front/queue/back wiring
// Path: a byte causing a beat is written into the queue, then into the result register,
// and m_valid rises once the result register holds it.
// Throughput: one byte per cycle unless the queue is full; a chunk-closing byte yields
// two beats, so the single result port (one beat per cycle) sets their sustained rate.
// The four-entry command queue lets the front keep taking bytes while results stall.
// Reset (aresetn low at a clock edge) returns to idle, crc to all ones, limit to 56320.
module image_download_receiver_crc32_core import idr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [2:0]  m_response_code,
    output logic [23:0] m_byte_offset,
    output logic [7:0]  m_data_byte,
    output logic [31:0] m_computed_crc,
    output logic        m_last
);

    logic [MAXLEN_W-1:0] max_len_reg;
    logic                cfg_wr;
    logic                q_full;
    logic                q_push;
    cmd_t                q_cmd;
    logic                q_pop;
    logic                head_valid;
    cmd_t                head_cmd;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_IMAGE_LENGTH);
    assign prdata = (paddr[2] == REG_MAX_IMAGE_LENGTH) ? {8'h00, max_len_reg} : 32'h0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= MAXLEN_RESET;
        end else if (cfg_wr) begin
            max_len_reg <= pwdata[MAXLEN_W-1:0];
        end
    end

    idr_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .max_image_length (max_len_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (q_cmd)
    );

    idr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    idr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_cmd        (head_cmd),
        .pop             (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_response_code (m_response_code),
        .m_byte_offset   (m_byte_offset),
        .m_data_byte     (m_data_byte),
        .m_computed_crc  (m_computed_crc),
        .m_last          (m_last)
    );

endmodule

/* hw/rtl/idr_front.sv */
// front end: parses the received byte stream and issues commands to the queue
module idr_front import idr_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic [MAXLEN_W-1:0] max_image_length,
    input  logic                q_full,
    output logic                q_push,
    output cmd_t                q_cmd
);

    phase_t             phase_reg, phase_next;
    logic [1:0]         idx_reg, idx_next;
    logic [23:0]        len_reg, len_next;
    logic [23:0]        rcvd_reg, rcvd_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [23:0]        exp_reg, exp_next;

    logic               accept;
    logic [23:0]        rcvd_inc;
    logic [FILL_W-1:0]  fill_inc;
    logic               chunk_done;
    logic               image_done;
    logic               len_bad;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign rcvd_inc   = rcvd_reg + 24'd1;
    assign fill_inc   = fill_reg + FILL_W'(1);
    assign image_done = (rcvd_inc >= len_reg);
    assign chunk_done = (fill_inc == FILL_W'(CHUNK_BYTES)) || image_done;
    // top length byte must be zero since the limit is 24 bits wide
    assign len_bad    = (s_rx_byte != 8'h00) || (len_reg == 24'd0) ||
                        (len_reg > max_image_length);

    // protocol decode
    always_comb begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        rcvd_next  = rcvd_reg;
        fill_next  = fill_reg;
        exp_next   = exp_reg;
        q_push     = 1'b0;
        q_cmd.op       = OP_ERROR;
        q_cmd.offset   = rcvd_reg;
        q_cmd.data     = s_rx_byte;
        q_cmd.ack      = chunk_done;
        q_cmd.expected = {s_rx_byte, exp_reg};
        if (accept) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (s_rx_byte == CMD_REQUEST) phase_next = PH_LEN_CMD;
                end
                PH_LEN_CMD: begin
                    if (s_rx_byte == CMD_LENGTH) begin
                        phase_next = PH_LEN_BYTES;
                        idx_next   = 2'd0;
                    end else begin
                        phase_next = PH_IDLE;
                        q_push     = 1'b1;
                    end
                end
                PH_LEN_BYTES: begin
                    idx_next = idx_reg + 2'd1;
                    case (idx_reg)
                        2'd0: len_next = {16'h0, s_rx_byte};
                        2'd1: len_next[15:8]  = s_rx_byte;
                        2'd2: len_next[23:16] = s_rx_byte;
                        default: begin
                            q_push = 1'b1;
                            if (len_bad) begin
                                phase_next = PH_IDLE;
                            end else begin
                                phase_next = PH_DATA;
                                q_cmd.op   = OP_START;
                                rcvd_next  = 24'd0;
                                fill_next  = '0;
                            end
                        end
                    endcase
                end
                PH_DATA: begin
                    q_push    = 1'b1;
                    q_cmd.op  = OP_STORE;
                    rcvd_next = rcvd_inc;
                    fill_next = chunk_done ? '0 : fill_inc;
                    if (image_done) phase_next = PH_CRC_CMD;
                end
                PH_CRC_CMD: begin
                    if (s_rx_byte == CMD_CRC) begin
                        phase_next = PH_CRC_BYTES;
                        idx_next   = 2'd0;
                    end else begin
                        phase_next = PH_IDLE;
                        q_push     = 1'b1;
                    end
                end
                PH_CRC_BYTES: begin
                    idx_next = idx_reg + 2'd1;
                    case (idx_reg)
                        2'd0: exp_next = {16'h0, s_rx_byte};
                        2'd1: exp_next[15:8]  = s_rx_byte;
                        2'd2: exp_next[23:16] = s_rx_byte;
                        default: begin
                            q_push     = 1'b1;
                            q_cmd.op   = OP_CHECK;
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            idx_reg   <= 2'd0;
            len_reg   <= 24'd0;
            rcvd_reg  <= 24'd0;
            fill_reg  <= '0;
            exp_reg   <= 24'd0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            rcvd_reg  <= rcvd_next;
            fill_reg  <= fill_next;
            exp_reg   <= exp_next;
        end
    end

    // a chunk never overfills, and the data phase never runs past the length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < FILL_W'(CHUNK_BYTES))
        else $error("chunk fill reached chunk size");
    a_data_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> rcvd_reg < len_reg)
        else $error("data phase past image length");
    a_push_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> accept)
        else $error("command issued without an accepted beat");

endmodule

/* hw/rtl/idr_queue.sv */
// short command queue between front and back
module idr_queue import idr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue underflow");
    a_ptr_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || full) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");

endmodule

/* hw/rtl/idr_back.sv */
// back end: runs queued commands, keeps the crc and drives the result register
module idr_back import idr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [2:0]  m_response_code,
    output logic [23:0] m_byte_offset,
    output logic [7:0]  m_data_byte,
    output logic [31:0] m_computed_crc,
    output logic        m_last
);

    logic        valid_reg, valid_next;
    logic        ack_pend_reg, ack_pend_next;
    logic [31:0] crc_reg, crc_next;
    logic        kind_reg, kind_next;
    logic [2:0]  code_reg, code_next;
    logic [23:0] off_reg, off_next;
    logic [7:0]  data_reg, data_next;
    logic [31:0] ccrc_reg, ccrc_next;
    logic        last_reg, last_next;

    logic        take;
    logic [31:0] crc_final;

    assign take      = head_valid && (!valid_reg || m_ready);
    assign crc_final = crc_reg ^ CRC_INIT;

    // command execution; a store that closes a chunk gives two beats
    always_comb begin
        valid_next    = valid_reg && !m_ready;
        ack_pend_next = ack_pend_reg;
        crc_next      = crc_reg;
        kind_next     = kind_reg;
        code_next     = code_reg;
        off_next      = off_reg;
        data_next     = data_reg;
        ccrc_next     = ccrc_reg;
        last_next     = last_reg;
        pop           = 1'b0;
        if (take) begin
            valid_next = 1'b1;
            kind_next  = KIND_REPLY;
            code_next  = RSP_ERR;
            off_next   = 24'd0;
            data_next  = 8'd0;
            ccrc_next  = 32'd0;
            last_next  = 1'b1;
            pop        = 1'b1;
            if (ack_pend_reg) begin
                code_next     = RSP_CHUNK;
                ack_pend_next = 1'b0;
            end else begin
                case (head_cmd.op)
                    OP_ERROR: code_next = RSP_ERR;
                    OP_START: begin
                        code_next = RSP_OK;
                        crc_next  = CRC_INIT;
                    end
                    OP_STORE: begin
                        kind_next     = KIND_STORE;
                        off_next      = head_cmd.offset;
                        data_next     = head_cmd.data;
                        last_next     = !head_cmd.ack;
                        crc_next      = crc_byte(crc_reg, head_cmd.data);
                        ack_pend_next = head_cmd.ack;
                        pop           = !head_cmd.ack;
                    end
                    OP_CHECK: begin
                        code_next = (crc_final == head_cmd.expected) ? RSP_CRC_OK
                                                                     : RSP_CRC_ERR;
                        ccrc_next = crc_final;
                    end
                    default: code_next = RSP_ERR;
                endcase
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            ack_pend_reg <= 1'b0;
            crc_reg      <= CRC_INIT;
        end else begin
            valid_reg    <= valid_next;
            ack_pend_reg <= ack_pend_next;
            crc_reg      <= crc_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        code_reg <= code_next;
        off_reg  <= off_next;
        data_reg <= data_next;
        ccrc_reg <= ccrc_next;
        last_reg <= last_next;
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_response_code = code_reg;
    assign m_byte_offset   = off_reg;
    assign m_data_byte     = data_reg;
    assign m_computed_crc  = ccrc_reg;
    assign m_last          = last_reg;

    a_ack_head: assert property (@(posedge aclk) disable iff (!aresetn)
        ack_pend_reg |-> head_valid && head_cmd.op == OP_STORE && head_cmd.ack)
        else $error("pending chunk reply without its store at the queue head");
    a_ack_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        ack_pend_reg |-> valid_reg && kind_reg == KIND_STORE && !last_reg)
        else $error("pending chunk reply without a preceding store beat");
    a_crc_only_check: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && ccrc_reg != 32'd0 |->
            code_reg == RSP_CRC_OK || code_reg == RSP_CRC_ERR)
        else $error("crc value on a beat that is no checksum reply");

endmodule

/* dv/tb_image_download_receiver_crc32_core.sv */
// self-checking testbench for the image download receiver with crc-32 check
module tb_image_download_receiver_crc32_core import idr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // run limits
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOW_LIMIT    = 30;
    localparam logic [2:0] ADDR_MAX_IMAGE_LENGTH = {REG_MAX_IMAGE_LENGTH, 2'b00};

    // one result beat as seen on the m_ side
    typedef struct {
        logic        kind;
        logic [2:0]  code;
        logic [23:0] offset;
        logic [7:0]  data;
        logic [31:0] crc;
        logic        last;
    } result_beat_t;

    // tracks the download protocol and holds the result beats still owed
    class download_tracker;
        result_beat_t awaited_beats[$];
        logic [23:0]  limit;
        phase_t       ph;
        logic [1:0]   field_idx;
        logic [31:0]  length_acc;
        logic [23:0]  rx_count;
        logic [8:0]   fill;
        logic [31:0]  crc_reg;
        logic [31:0]  crc_rx;
        int           errors;

        function new();
            limit      = MAXLEN_RESET;
            ph         = PH_IDLE;
            field_idx  = '0;
            length_acc = '0;
            rx_count   = '0;
            fill       = '0;
            crc_reg    = CRC_INIT;
            crc_rx     = '0;
            errors     = 0;
        endfunction

        function void set_limit(logic [31:0] value);
            limit = value[23:0];
        endfunction

        function int owed();
            return awaited_beats.size();
        endfunction

        // crc of the image bytes taken so far, final xor applied
        function logic [31:0] image_crc();
            return crc_reg ^ CRC_INIT;
        endfunction

        // reflected crc, one data bit at a time
        function logic [31:0] fold_crc(logic [31:0] c_in, logic [7:0] b);
            logic [31:0] c;
            logic        fb;
            c = c_in;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) c = c ^ CRC_POLY;
            end
            return c;
        endfunction

        function void owe(logic kind, logic [2:0] code, logic [23:0] offset,
                          logic [7:0] data, logic [31:0] crc, logic last);
            result_beat_t r;
            r.kind   = kind;
            r.code   = code;
            r.offset = offset;
            r.data   = data;
            r.crc    = crc;
            r.last   = last;
            awaited_beats.push_back(r);
        endfunction

        // advance the protocol by one accepted byte
        function void take_rx_byte(logic [7:0] b);
            logic [23:0] off;
            logic [31:0] final_crc;
            logic        done;
            case (ph)
                PH_IDLE: begin
                    if (b == CMD_REQUEST) ph = PH_LEN_CMD;
                end
                PH_LEN_CMD: begin
                    if (b == CMD_LENGTH) begin
                        ph        = PH_LEN_BYTES;
                        field_idx = '0;
                    end else begin
                        ph = PH_IDLE;
                        owe(KIND_REPLY, RSP_ERR, '0, '0, '0, 1'b1);
                    end
                end
                PH_LEN_BYTES: begin
                    if (field_idx == 2'd0) length_acc = {24'h0, b};
                    else length_acc = length_acc | ({24'h0, b} << (8 * field_idx));
                    if (field_idx != 2'd3) begin
                        field_idx = field_idx + 2'd1;
                    end else begin
                        field_idx = '0;
                        if (length_acc == 32'd0 || length_acc > {8'h0, limit}) begin
                            ph = PH_IDLE;
                            owe(KIND_REPLY, RSP_ERR, '0, '0, '0, 1'b1);
                        end else begin
                            ph       = PH_DATA;
                            rx_count = '0;
                            fill     = '0;
                            crc_reg  = CRC_INIT;
                            owe(KIND_REPLY, RSP_OK, '0, '0, '0, 1'b1);
                        end
                    end
                end
                PH_DATA: begin
                    off      = rx_count;
                    crc_reg  = fold_crc(crc_reg, b);
                    rx_count = rx_count + 24'd1;
                    fill     = fill + 9'd1;
                    done     = ({8'h0, rx_count} >= length_acc);
                    if (fill >= CHUNK_BYTES || done) begin
                        owe(KIND_STORE, '0, off, b, '0, 1'b0);
                        owe(KIND_REPLY, RSP_CHUNK, '0, '0, '0, 1'b1);
                        fill = '0;
                        if (done) ph = PH_CRC_CMD;
                    end else begin
                        owe(KIND_STORE, '0, off, b, '0, 1'b1);
                    end
                end
                PH_CRC_CMD: begin
                    if (b == CMD_CRC) begin
                        ph        = PH_CRC_BYTES;
                        field_idx = '0;
                    end else begin
                        ph = PH_IDLE;
                        owe(KIND_REPLY, RSP_ERR, '0, '0, '0, 1'b1);
                    end
                end
                PH_CRC_BYTES: begin
                    if (field_idx == 2'd0) crc_rx = {24'h0, b};
                    else crc_rx = crc_rx | ({24'h0, b} << (8 * field_idx));
                    if (field_idx != 2'd3) begin
                        field_idx = field_idx + 2'd1;
                    end else begin
                        field_idx = '0;
                        ph        = PH_IDLE;
                        final_crc = crc_reg ^ CRC_INIT;
                        owe(KIND_REPLY, (final_crc == crc_rx) ? RSP_CRC_OK : RSP_CRC_ERR,
                            '0, '0, final_crc, 1'b1);
                    end
                end
                default: ph = PH_IDLE;
            endcase
        endfunction

        function string show(result_beat_t r);
            return $sformatf("kind %0d code %0d off %0d data %02h crc %08h last %0d",
                             r.kind, r.code, r.offset, r.data, r.crc, r.last);
        endfunction

        task report(string what);
            if (errors < SHOW_LIMIT) $display("mismatch: %s", what);
            errors++;
        endtask

        // compare one delivered beat against the oldest one owed
        task match_beat(result_beat_t got);
            result_beat_t want;
            if (awaited_beats.size() == 0) begin
                report({"unexpected beat ", show(got)});
            end else begin
                want = awaited_beats.pop_front();
                if (got.kind !== want.kind || got.code !== want.code ||
                    got.offset !== want.offset || got.data !== want.data ||
                    got.crc !== want.crc || got.last !== want.last)
                    report({"got ", show(got), " want ", show(want)});
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid  = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = '0;
    logic        m_valid;
    logic        m_ready  = 1'b0;
    logic        m_kind;
    logic [2:0]  m_response_code;
    logic [23:0] m_byte_offset;
    logic [7:0]  m_data_byte;
    logic [31:0] m_computed_crc;
    logic        m_last;

    download_tracker tracker = new();
    int cycles      = 0;
    int burst_left  = 0;
    int bytes_sent  = 0;
    int stall_left  = 0;
    int stall_mode  = 0;

    image_download_receiver_crc32_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_response_code (m_response_code),
        .m_byte_offset   (m_byte_offset),
        .m_data_byte     (m_data_byte),
        .m_computed_crc  (m_computed_crc),
        .m_last          (m_last)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: stall pattern and beat checking
    always @(posedge aclk) begin
        result_beat_t got;
        if (aresetn && m_valid && m_ready) begin
            got.kind   = m_kind;
            got.code   = m_response_code;
            got.offset = m_byte_offset;
            got.data   = m_data_byte;
            got.crc    = m_computed_crc;
            got.last   = m_last;
            tracker.match_beat(got);
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (cycles % 5) != 0;
            default: m_ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // one byte beat on the s_ side, in bursts with random gaps
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.take_rx_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    // little-endian 32-bit field
    task automatic send_word(input logic [31:0] v);
        for (int i = 0; i < 4; i++) send_byte(v[8*i +: 8]);
    endtask

    task automatic send_image(input int len);
        logic [7:0] b;
        int         pick;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) b = 8'h00;
            else if (pick == 1) b = 8'hFF;
            else b = 8'($urandom);
            send_byte(b);
        end
    endtask

    // stop sending until every owed beat has arrived
    task automatic hold_until_drained();
        s_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (tracker.owed() != 0);
    endtask

    // drained and settled, safe to touch the register
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MAX_IMAGE_LENGTH) tracker.set_limit(data);
    endtask

    // one random transaction, always leaving the protocol back in idle
    task automatic random_transfer();
        int          pick;
        int          n;
        int          len;
        int          lim;
        logic [31:0] v;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        lim  = int'(tracker.limit);
        if ($urandom_range(0, 29) == 0) hold_until_drained();
        if (pick < 75) begin
            // well-formed header and image
            n = $urandom_range(0, 99);
            if (n < 70) len = $urandom_range(1, 40);
            else if (n < 92) len = $urandom_range(41, 300);
            else len = $urandom_range(301, 700);
            if (len > lim) len = lim;
            if (lim <= 700 && $urandom_range(0, 9) == 0) len = lim;
            send_byte(CMD_REQUEST);
            send_byte(CMD_LENGTH);
            send_word(32'(len));
            send_image(len);
            if (pick >= 70) begin
                // wrong command after the image
                do b = 8'($urandom); while (b == CMD_CRC);
                send_byte(b);
            end else begin
                v = tracker.image_crc();
                if (pick >= 65) v = v ^ (32'h1 << $urandom_range(0, 31));
                else if (pick >= 60) v = $urandom;
                send_byte(CMD_CRC);
                send_word(v);
            end
        end else if (pick < 80) begin
            // wrong command after the request
            send_byte(CMD_REQUEST);
            do b = 8'($urandom); while (b == CMD_LENGTH);
            send_byte(b);
        end else if (pick < 90) begin
            // zero or over-limit length
            n = $urandom_range(0, 3);
            if (n == 0) v = '0;
            else if (n == 1) v = {8'h0, tracker.limit} + 32'd1;
            else begin
                v = $urandom;
                if (v != 0 && v <= {8'h0, tracker.limit}) v[31:24] = 8'($urandom_range(1, 255));
            end
            send_byte(CMD_REQUEST);
            send_byte(CMD_LENGTH);
            send_word(v);
        end else begin
            // idle noise, ignored by the block
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                do b = 8'($urandom); while (b == CMD_REQUEST);
                send_byte(b);
                bytes_sent--;
            end
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at) random_transfer();
    endtask

    // main sequence
    initial begin
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle noise, bad command, zero and over-limit length, good image
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CMD_REQUEST);
        send_byte(8'h07);
        send_byte(CMD_REQUEST);
        send_byte(CMD_LENGTH);
        send_word(32'd0);
        send_byte(CMD_REQUEST);
        send_byte(CMD_LENGTH);
        send_word({8'h0, MAXLEN_RESET} + 32'd1);
        send_byte(CMD_REQUEST);
        send_byte(CMD_LENGTH);
        send_word(32'd1);
        send_byte(8'hFF);
        send_byte(CMD_CRC);
        send_word(tracker.image_crc());

        // limit of zero rejects every length
        settle();
        apb_write(ADDR_MAX_IMAGE_LENGTH, 32'd0);
        send_byte(CMD_REQUEST);
        send_byte(CMD_LENGTH);
        send_word(32'd1);

        // limit of one, upper bits of the write dropped
        settle();
        apb_write(ADDR_MAX_IMAGE_LENGTH, 32'hA500_0001);
        send_byte(CMD_REQUEST);
        send_byte(CMD_LENGTH);
        send_word(32'd1);
        send_byte(8'h00);
        send_byte(CMD_CRC);
        send_word(tracker.image_crc());
        send_byte(CMD_REQUEST);
        send_byte(CMD_LENGTH);
        send_word(32'd2);

        // largest limit
        settle();
        apb_write(ADDR_MAX_IMAGE_LENGTH, 32'hFFFF_FFFF);
        run_random(500);

        // limit changed while the length field has three of its four bytes received
        settle();
        send_byte(CMD_REQUEST);
        send_byte(CMD_LENGTH);
        send_byte(8'd5);
        send_byte(8'd0);
        send_byte(8'd0);
        settle();
        apb_write(ADDR_MAX_IMAGE_LENGTH, 32'd4);
        send_byte(8'd0);

        // small random limit, chunks rarely fill
        settle();
        apb_write(ADDR_MAX_IMAGE_LENGTH, 32'($urandom_range(1, 700)));
        run_random(450);

        // back to the reset value
        settle();
        apb_write(ADDR_MAX_IMAGE_LENGTH, {8'h0, MAXLEN_RESET});
        run_random(450);

        settle();
        if (tracker.errors == 0 && tracker.owed() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/idr_pkg.sv
hw/rtl/idr_front.sv
hw/rtl/idr_queue.sv
hw/rtl/idr_back.sv
hw/rtl/image_download_receiver_crc32_core.sv
dv/tb_image_download_receiver_crc32_core.sv
